/* rtl/window_peak_count_max_unit_defines.svh */
// Assertion macros used by wpc_checker, the verification file of the window peak counter.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef WINDOW_PEAK_COUNT_MAX_UNIT_DEFINES_SVH
`define WINDOW_PEAK_COUNT_MAX_UNIT_DEFINES_SVH

// Condition that must hold in the same cycle as its trigger.
`define WPC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("window peak count check failed");

// Condition that must hold in the cycle after its trigger.
`define WPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("window peak count check failed");

`endif

/* rtl/wpc_pkg.sv */
// Shared widths, limits and the item record passed between the front end,
// the queue and the back end of the window peak counter. No dependencies.
package wpc_pkg;

	localparam int SAMPLE_W    = 16;  // sample field on the input stream
	localparam int IDX_W       = 16;  // sample position and window start
	localparam int CNT_W       = 10;  // peak counts
	localparam int PARTS_W     = 10;  // best_parts result field
	localparam int WL_W        = 11;  // window_length register
	localparam int EFF_W       = 17;  // clamped window length, holds up to 65536
	localparam int IN_DATA_W   = 16;
	localparam int OUT_DATA_W  = 32;
	localparam int OUT_PAD_W   = OUT_DATA_W - PARTS_W - IDX_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	localparam logic [IDX_W-1:0] IDX_MAX    = '1;
	localparam logic [CNT_W-1:0] CNT_MAX    = '1;
	localparam logic [EFF_W-1:0] MIN_EFF    = EFF_W'(3);
	localparam logic [WL_W-1:0]  MIN_LENGTH = WL_W'(3);

	// One classified sample, ready for the counting logic.
	typedef struct packed {
		logic             peak;   // the sample before this one is a peak
		logic             drop;   // a peak leaves the window on this sample
		logic             check;  // a complete window ends on this sample
		logic [IDX_W-1:0] left;   // 1-based start of that window
		logic             last;   // closes the sequence
	} wpc_item_t;

endpackage

/* rtl/wpc_front.sv */
// Front end of the window peak counter: takes samples, detects peaks, keeps
// the peak flag ring and classifies each sample into a wpc_item_t. Uses wpc_pkg.
module wpc_front #(
	parameter int MAX_WINDOW  = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [wpc_pkg::WL_W-1:0]    cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [wpc_pkg::SAMPLE_W-1:0] in_sample,
	input  logic                        in_last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output wpc_pkg::wpc_item_t          out_item
);
	import wpc_pkg::*;

	localparam int KEEP_BITS  = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
	// The ring is rounded up to a power of two; a read always lands on a
	// position less than MAX_WINDOW behind the write, so the answers match.
	localparam int ADDR_BITS  = $clog2(MAX_WINDOW);
	localparam int RING_DEPTH = 1 << ADDR_BITS;
	localparam logic [EFF_W-1:0] MAX_EFF = EFF_W'(MAX_WINDOW);

	logic [EFF_W-1:0]     eff_q;
	logic                 len_ok_q;
	logic [EFF_W-1:0]     cfg_ext;
	logic [EFF_W-1:0]     cfg_eff;

	logic [KEEP_BITS-1:0] older_q;
	logic [KEEP_BITS-1:0] newer_q;
	logic [IDX_W-1:0]     idx_q;

	logic                 ring_q [RING_DEPTH];

	logic                 valid_s1;
	logic                 peak_s1;
	logic                 leave_s1;
	logic                 check_s1;
	logic [IDX_W-1:0]     left_s1;
	logic                 last_s1;
	logic                 gone_s1;

	logic                 accept;
	logic [KEEP_BITS-1:0] cur;
	logic [EFF_W-1:0]     idx_ext;
	logic                 has_pair;
	logic                 peak;
	logic                 leave_ok;
	logic                 check;
	logic [EFF_W-1:0]     left_full;
	logic [EFF_W-1:0]     gone_pos;
	logic [IDX_W-1:0]     wr_pos;
	logic [ADDR_BITS-1:0] rd_addr;
	logic [ADDR_BITS-1:0] wr_addr;

	assign cfg_ready = 1'b1;
	assign cfg_ext   = EFF_W'(cfg_data);

	always_comb begin
		if (cfg_ext < MIN_EFF) begin
			cfg_eff = MIN_EFF;
		end else if (cfg_ext > MAX_EFF) begin
			cfg_eff = MAX_EFF;
		end else begin
			cfg_eff = cfg_ext;
		end
	end

	assign in_ready = !valid_s1 || out_ready;
	assign accept   = in_valid && in_ready;
	assign cur      = in_sample[KEEP_BITS-1:0];
	assign idx_ext  = EFF_W'(idx_q);

	always_comb begin
		has_pair  = (idx_q[IDX_W-1:1] != '0);
		peak      = has_pair && (older_q < newer_q) && (newer_q > cur);
		leave_ok  = (idx_ext >= eff_q);
		check     = len_ok_q && ((idx_ext + EFF_W'(1)) >= eff_q);
		left_full = idx_ext + EFF_W'(2) - eff_q;
		gone_pos  = idx_ext + EFF_W'(1) - eff_q;
		wr_pos    = idx_q - IDX_W'(1);
		rd_addr   = gone_pos[ADDR_BITS-1:0];
		wr_addr   = wr_pos[ADDR_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (accept && has_pair) begin
			ring_q[wr_addr] <= peak;
		end
		if (accept) begin
			gone_s1 <= ring_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			peak_s1  <= peak;
			leave_s1 <= leave_ok;
			check_s1 <= check;
			left_s1  <= left_full[IDX_W-1:0];
			last_s1  <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			eff_q    <= MIN_EFF;
			len_ok_q <= 1'b1;
			older_q  <= '0;
			newer_q  <= '0;
			idx_q    <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (out_ready) begin
				valid_s1 <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				eff_q    <= cfg_eff;
				len_ok_q <= (cfg_data >= MIN_LENGTH);
			end
			if (accept) begin
				if (in_last) begin
					older_q <= '0;
					newer_q <= '0;
					idx_q   <= '0;
				end else begin
					older_q <= newer_q;
					newer_q <= cur;
					if (idx_q != IDX_MAX) begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
			end
		end
	end

	assign out_valid      = valid_s1;
	assign out_item.peak  = peak_s1;
	assign out_item.drop  = leave_s1 && gone_s1;
	assign out_item.check = check_s1;
	assign out_item.left  = left_s1;
	assign out_item.last  = last_s1;

endmodule

/* rtl/wpc_queue.sv */
// Short queue of classified samples between the front end and the back end
// of the window peak counter. Uses wpc_pkg for the item record and depth.
module wpc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  wpc_pkg::wpc_item_t in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output wpc_pkg::wpc_item_t out_item
);
	import wpc_pkg::*;

	localparam logic [QPTR_W:0] FULL_COUNT = (QPTR_W + 1)'(QUEUE_DEPTH);

	wpc_item_t         entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              pop;

	assign in_ready  = (count_q != FULL_COUNT);
	assign out_valid = (count_q != '0);
	assign out_item  = entry_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W + 1)'(1);
			end
		end
	end

endmodule

/* rtl/wpc_back.sv */
// Back end of the window peak counter: keeps the running window count and the
// best window, and holds the result in an output register. Uses wpc_pkg.
module wpc_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  wpc_pkg::wpc_item_t        in_item,
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic [wpc_pkg::PARTS_W-1:0] res_parts,
	output logic [wpc_pkg::IDX_W-1:0]   res_start
);
	import wpc_pkg::*;

	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   best_q;
	logic [IDX_W-1:0]   best_left_q;
	logic               res_valid_q;
	logic [PARTS_W-1:0] parts_q;
	logic [IDX_W-1:0]   start_q;

	logic               take;
	logic [CNT_W-1:0]   cnt_dec;
	logic [CNT_W-1:0]   cnt_new;
	logic               better;
	logic [CNT_W-1:0]   best_new;
	logic [IDX_W-1:0]   left_new;
	logic [PARTS_W-1:0] parts;

	// A sample that produces no result never waits for the output register.
	assign in_ready = !in_item.last || !res_valid_q || res_ready;
	assign take     = in_valid && in_ready;

	always_comb begin
		cnt_dec  = (in_item.drop && (cnt_q != '0)) ? cnt_q - CNT_W'(1) : cnt_q;
		cnt_new  = (in_item.peak && (cnt_dec != CNT_MAX)) ? cnt_dec + CNT_W'(1) : cnt_dec;
		better   = in_item.check && (cnt_new > best_q);
		best_new = better ? cnt_new : best_q;
		left_new = better ? in_item.left : best_left_q;
		parts    = (best_new == CNT_MAX) ? CNT_MAX : best_new + CNT_W'(1);
	end

	always_ff @(posedge clk) begin
		if (take && in_item.last) begin
			parts_q <= parts;
			start_q <= left_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			best_q      <= '0;
			best_left_q <= IDX_W'(1);
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				if (in_item.last) begin
					cnt_q       <= '0;
					best_q      <= '0;
					best_left_q <= IDX_W'(1);
				end else begin
					cnt_q       <= cnt_new;
					best_q      <= best_new;
					best_left_q <= left_new;
				end
			end
			if (take && in_item.last) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_parts = parts_q;
	assign res_start = start_q;

endmodule

/* rtl/window_peak_count_max_unit.sv */
// Top level of the sliding-window local peak counter.
// Instantiates wpc_front, wpc_queue and wpc_back; uses wpc_pkg.
//
//   channel   direction  handshake                       payload
//   cfg       in         cfg_valid / cfg_ready           cfg_data = window_length
//   s_axis    in         s_axis_tvalid / s_axis_tready   tdata = sample, tlast = last_sample
//   m_axis    out        m_axis_tvalid / m_axis_tready   tdata = best_parts, best_start
//
// The unit takes one sample beat every clock cycle while s_axis_tready is high.
// After the edge that accepts the beat carrying tlast, the front end's stage
// register is loaded with the peak ring read, then the queue is written, and
// then the output register is loaded, which raises m_axis_tvalid.
// Reset clears all sequence state and sets window_length to three; the peak
// ring needs no clearing pass, because a sequence only reads ring entries it
// has written itself. Beats without tlast never wait for the output. A result
// the sink has not taken blocks the back end only once the next beat with
// tlast reaches it; the four-entry queue and the front end's stage register
// then fill up and s_axis_tready drops.
//
// A sample is a peak when it is strictly greater than both neighbors. For
// each window of window_length samples, the peaks strictly inside it are
// counted; the result gives the largest count plus one and the 1-based start
// of the first window that reached it.
module window_peak_count_max_unit #(
	parameter int MAX_WINDOW  = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [wpc_pkg::WL_W-1:0]        cfg_data,       // window_length
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [wpc_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // [15:0] sample
	input  logic                            s_axis_tlast,   // last_sample
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [wpc_pkg::OUT_DATA_W-1:0]  m_axis_tdata    // [9:0] best_parts,
	                                                        // [25:10] best_start,
	                                                        // [31:26] zero
);
	import wpc_pkg::*;

	wpc_item_t          front_item;
	logic               front_valid;
	logic               front_ready;
	wpc_item_t          queue_item;
	logic               queue_valid;
	logic               queue_ready;
	logic [PARTS_W-1:0] res_parts;
	logic [IDX_W-1:0]   res_start;

	// Peak detection, the peak flag ring and window bookkeeping by position.
	wpc_front #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_sample (s_axis_tdata[SAMPLE_W-1:0]),
		.in_last   (s_axis_tlast),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_item  (front_item)
	);

	// Decouples the two halves so each can stall on its own.
	wpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_item   (front_item),
		.out_valid (queue_valid),
		.out_ready (queue_ready),
		.out_item  (queue_item)
	);

	// Running count, best window and the result register.
	wpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (queue_valid),
		.in_ready  (queue_ready),
		.in_item   (queue_item),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res_parts (res_parts),
		.res_start (res_start)
	);

	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res_start, res_parts};

endmodule

/* rtl/wpc_checker.sv */
// Port-level checks on the result stream of window_peak_count_max_unit, and
// the bind that attaches them. Uses wpc_pkg and the shared assertion macros.
`include "window_peak_count_max_unit_defines.svh"

module wpc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [wpc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import wpc_pkg::*;

	// A result beat that is not taken stays, unchanged.
	`WPC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// The count field is never zero: it holds the best count plus one, saturated at its maximum.
	`WPC_ASSERT_NOW(a_parts_nonzero, m_axis_tvalid, m_axis_tdata[PARTS_W-1:0] != '0)

	// Window starts are 1-based.
	`WPC_ASSERT_NOW(a_start_nonzero, m_axis_tvalid, m_axis_tdata[PARTS_W+IDX_W-1:PARTS_W] != '0)

	// Padding above the two fields stays zero.
	`WPC_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_DATA_W-1:PARTS_W+IDX_W] == '0)

endmodule

bind window_peak_count_max_unit wpc_checker u_wpc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
